/* src/srf_pkg.sv */
// Package: opcodes, sequencer states and shared constants of the shape rasterizer.
`timescale 1ns / 1ps
package srf_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_LINE   = 3'd1,
    OP_RECT   = 3'd2,
    OP_CIRCLE = 3'd3,
    OP_TRI    = 3'd4,
    OP_READ   = 3'd5
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CLEAR,
    ST_LSETUP,
    ST_LPLOT,
    ST_CPLOT,
    ST_CSTEP,
    ST_READ,
    ST_RWAIT,
    ST_OUT
  } state_t;

  localparam logic [7:0] FILL_RESET = 8'd95;

endpackage

/* src/srf_if.sv */
// Interfaces: command, result and configuration channels.
`timescale 1ns / 1ps
interface srf_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic signed [9:0] ax;
  logic signed [9:0] ay;
  logic signed [9:0] bx;
  logic signed [9:0] by;
  logic signed [9:0] cx;
  logic signed [9:0] cy;
  logic [8:0]        radius;
  logic [7:0]        symbol;
  modport source (output valid, opcode, ax, ay, bx, by, cx, cy, radius, symbol, input ready);
  modport sink   (input valid, opcode, ax, ay, bx, by, cx, cy, radius, symbol, output ready);
endinterface

interface srf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_value;
  logic       in_range;
  modport source (output valid, cell_value, in_range, input ready);
  modport sink   (input valid, cell_value, in_range, output ready);
endinterface

interface srf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/shape_rasterizer_framebuffer_top.sv */
// Top level: character framebuffer with a sequenced line / circle raster engine.
`timescale 1ns / 1ps
// Drawing: clear sweeps the canvas one cell a cycle; a line passes a setup state (ST_LSETUP),
//   then plots in ST_LPLOT; rectangles and triangles chain 4 or 3 lines; a circle plots eight octant points per step.
// A read passes ST_READ and ST_RWAIT, then offers its result in ST_OUT; items are taken one at a time.
// The single shared line stepper and the one memory write port serialise all drawing.
// Reset: after rst_n the canvas is swept to the fill character, one cell a cycle,
//   while no command is accepted; config writes are taken throughout.
module shape_rasterizer_framebuffer_top #(
  parameter int CANVAS_WIDTH  = 80,
  parameter int CANVAS_HEIGHT = 25
) (
  input  logic clk,
  input  logic rst_n,
  srf_cmd_if.sink   in_ch,
  srf_res_if.source out_ch,
  srf_cfg_if.sink   cfg_ch
);

  localparam int CELLS = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  // coordinate width: wide enough for all intermediates of lines and circles
  localparam int CW    = 13;

  logic [7:0] mem [CELLS];

  srf_pkg::state_t state_r, state_nxt;
  logic [7:0]  fill_r;
  logic [2:0]  op_r;
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [8:0]  rad_r;
  logic [7:0]  sym_r;
  logic [1:0]  seg_r, seg_nxt;
  logic [AW:0] clr_r, clr_nxt;

  // line stepper
  logic signed [CW-1:0] x0_r, y0_r, x1_r, y1_r, dx_r, dy_r, err_r;
  logic signed [CW-1:0] x0_nxt, y0_nxt, x1_nxt, y1_nxt, dx_nxt, dy_nxt, err_nxt;
  logic sx_r, sy_r, sx_nxt, sy_nxt;

  // circle stepper
  logic signed [CW-1:0] cxs_r, cys_r, cd_r, cxs_nxt, cys_nxt, cd_nxt;
  logic [2:0] oct_r, oct_nxt;

  logic [7:0] rd_r;
  logic       inr_r, inr_nxt;
  logic [7:0] oval_r;
  logic       orng_r;
  logic       ldr;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= srf_pkg::FILL_RESET;
    end else if (cfg_ch.valid) begin
      fill_r <= cfg_ch.data;
    end
  end

  // plot point chosen this cycle
  logic signed [CW-1:0] px, py;
  logic        pen;
  logic [7:0]  pdat;
  logic [AW-1:0] paddr;
  logic        pon;

  always_comb begin
    px = x0_r;
    py = y0_r;
    case (oct_r)
      3'd0: begin px = ax_r + cxs_r; py = ay_r + cys_r; end
      3'd1: begin px = ax_r - cxs_r; py = ay_r + cys_r; end
      3'd2: begin px = ax_r + cxs_r; py = ay_r - cys_r; end
      3'd3: begin px = ax_r - cxs_r; py = ay_r - cys_r; end
      3'd4: begin px = ax_r + cys_r; py = ay_r + cxs_r; end
      3'd5: begin px = ax_r - cys_r; py = ay_r + cxs_r; end
      3'd6: begin px = ax_r + cys_r; py = ay_r - cxs_r; end
      default: begin px = ax_r - cys_r; py = ay_r - cxs_r; end
    endcase
    if (state_r != srf_pkg::ST_CPLOT) begin
      px = x0_r;
      py = y0_r;
    end
    if (state_r == srf_pkg::ST_READ) begin
      px = ax_r;
      py = ay_r;
    end
    pon = (px >= 0) && (px < CW'(CANVAS_WIDTH)) && (py >= 0) && (py < CW'(CANVAS_HEIGHT));
    paddr = AW'(py * CW'(CANVAS_WIDTH) + px);
  end

  // line segment endpoints for the current segment
  logic signed [CW-1:0] sa_x, sa_y, sb_x, sb_y;
  always_comb begin
    sa_x = ax_r; sa_y = ay_r; sb_x = bx_r; sb_y = by_r;
    case (srf_pkg::opcode_t'(op_r))
      srf_pkg::OP_RECT: begin
        case (seg_r)
          2'd0: begin sa_x = ax_r; sa_y = ay_r; sb_x = bx_r; sb_y = ay_r; end
          2'd1: begin sa_x = bx_r; sa_y = ay_r; sb_x = bx_r; sb_y = by_r; end
          2'd2: begin sa_x = bx_r; sa_y = by_r; sb_x = ax_r; sb_y = by_r; end
          default: begin sa_x = ax_r; sa_y = by_r; sb_x = ax_r; sb_y = ay_r; end
        endcase
      end
      srf_pkg::OP_TRI: begin
        case (seg_r)
          2'd0: begin sa_x = ax_r; sa_y = ay_r; sb_x = bx_r; sb_y = by_r; end
          2'd1: begin sa_x = bx_r; sa_y = by_r; sb_x = cx_r; sb_y = cy_r; end
          default: begin sa_x = cx_r; sa_y = cy_r; sb_x = ax_r; sb_y = ay_r; end
        endcase
      end
      default: ;
    endcase
  end

  logic signed [CW-1:0] e2, adx, ady, tnx;
  logic last_seg;
  always_comb begin
    state_nxt = state_r;
    seg_nxt = seg_r;
    clr_nxt = clr_r;
    x0_nxt = x0_r; y0_nxt = y0_r; x1_nxt = x1_r; y1_nxt = y1_r;
    dx_nxt = dx_r; dy_nxt = dy_r; err_nxt = err_r; sx_nxt = sx_r; sy_nxt = sy_r;
    cxs_nxt = cxs_r; cys_nxt = cys_r; cd_nxt = cd_r; oct_nxt = oct_r;
    inr_nxt = inr_r;
    pen = 1'b0;
    pdat = sym_r;
    ldr = 1'b0;
    e2 = err_r <<< 1;
    adx = (sb_x > sa_x) ? sb_x - sa_x : sa_x - sb_x;
    ady = (sb_y > sa_y) ? sb_y - sa_y : sa_y - sb_y;
    tnx = cxs_r + CW'(1);
    last_seg = (op_r == srf_pkg::OP_LINE) || (op_r == srf_pkg::OP_RECT && seg_r == 2'd3) ||
               (op_r == srf_pkg::OP_TRI && seg_r == 2'd2);
    case (state_r)
      srf_pkg::ST_INIT, srf_pkg::ST_CLEAR: begin
        pen = 1'b1;
        pdat = (state_r == srf_pkg::ST_INIT) ? srf_pkg::FILL_RESET : fill_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(CELLS - 1)) begin
          state_nxt = srf_pkg::ST_IDLE;
        end
      end
      srf_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          seg_nxt = 2'd0;
          clr_nxt = '0;
          oct_nxt = 3'd0;
          case (srf_pkg::opcode_t'(in_ch.opcode))
            srf_pkg::OP_CLEAR: state_nxt = srf_pkg::ST_CLEAR;
            srf_pkg::OP_LINE, srf_pkg::OP_RECT, srf_pkg::OP_TRI:
              state_nxt = srf_pkg::ST_LSETUP;
            srf_pkg::OP_CIRCLE: begin
              state_nxt = srf_pkg::ST_CPLOT;
              cxs_nxt = '0;
              cys_nxt = CW'(in_ch.radius);
              cd_nxt = CW'(3) - (CW'(in_ch.radius) <<< 1);
            end
            srf_pkg::OP_READ: state_nxt = srf_pkg::ST_READ;
            default: state_nxt = srf_pkg::ST_IDLE;
          endcase
        end
      end
      srf_pkg::ST_LSETUP: begin
        x0_nxt = sa_x; y0_nxt = sa_y; x1_nxt = sb_x; y1_nxt = sb_y;
        dx_nxt = adx; dy_nxt = ady;
        sx_nxt = sa_x < sb_x; sy_nxt = sa_y < sb_y;
        err_nxt = adx - ady;
        state_nxt = srf_pkg::ST_LPLOT;
      end
      srf_pkg::ST_LPLOT: begin
        pen = pon;
        if (x0_r == x1_r && y0_r == y1_r) begin
          seg_nxt = seg_r + 1'b1;
          state_nxt = last_seg ? srf_pkg::ST_IDLE : srf_pkg::ST_LSETUP;
        end else begin
          err_nxt = err_r;
          if (e2 > -dy_r) begin
            err_nxt = err_nxt - dy_r;
            x0_nxt = sx_r ? x0_r + CW'(1) : x0_r - CW'(1);
          end
          if (e2 < dx_r) begin
            err_nxt = err_nxt + dx_r;
            y0_nxt = sy_r ? y0_r + CW'(1) : y0_r - CW'(1);
          end
        end
      end
      srf_pkg::ST_CPLOT: begin
        if (cys_r < cxs_r) begin
          state_nxt = srf_pkg::ST_IDLE;
        end else begin
          pen = pon;
          oct_nxt = oct_r + 1'b1;
          if (oct_r == 3'd7) state_nxt = srf_pkg::ST_CSTEP;
        end
      end
      srf_pkg::ST_CSTEP: begin
        cxs_nxt = tnx;
        if (cd_r > 0) begin
          cys_nxt = cys_r - CW'(1);
          cd_nxt = cd_r + ((tnx - cys_r + CW'(1)) <<< 2) + CW'(10);
        end else begin
          cd_nxt = cd_r + (tnx <<< 2) + CW'(6);
        end
        state_nxt = srf_pkg::ST_CPLOT;
      end
      srf_pkg::ST_READ: begin
        inr_nxt = pon;
        state_nxt = srf_pkg::ST_RWAIT;
      end
      srf_pkg::ST_RWAIT: begin
        ldr = 1'b1;
        state_nxt = srf_pkg::ST_OUT;
      end
      srf_pkg::ST_OUT: begin
        if (out_ch.ready) state_nxt = srf_pkg::ST_IDLE;
      end
      default: state_nxt = srf_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == srf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srf_pkg::ST_INIT;
      clr_r   <= '0;
      seg_r   <= '0;
      oct_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      seg_r   <= seg_nxt;
      oct_r   <= oct_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.opcode;
      ax_r  <= CW'(in_ch.ax); ay_r <= CW'(in_ch.ay);
      bx_r  <= CW'(in_ch.bx); by_r <= CW'(in_ch.by);
      cx_r  <= CW'(in_ch.cx); cy_r <= CW'(in_ch.cy);
      rad_r <= in_ch.radius;
      sym_r <= in_ch.symbol;
    end
    x0_r <= x0_nxt; y0_r <= y0_nxt; x1_r <= x1_nxt; y1_r <= y1_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; err_r <= err_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    cxs_r <= cxs_nxt; cys_r <= cys_nxt; cd_r <= cd_nxt;
    inr_r <= inr_nxt;
    if (ldr) begin
      oval_r <= inr_r ? rd_r : 8'd0;
      orng_r <= inr_r;
    end
  end

  // canvas memory: one write port, one registered read port
  logic [AW-1:0] waddr;
  assign waddr = (state_r == srf_pkg::ST_INIT || state_r == srf_pkg::ST_CLEAR)
                 ? clr_r[AW-1:0] : paddr;
  always_ff @(posedge clk) begin
    if (pen) mem[waddr] <= pdat;
    rd_r <= mem[paddr];
  end

  assign out_ch.valid      = (state_r == srf_pkg::ST_OUT);
  assign out_ch.cell_value = oval_r;
  assign out_ch.in_range   = orng_r;

  // hold the result until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.cell_value))
    else $error("result dropped while stalled");
  // drop no command while busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != srf_pkg::ST_IDLE) |-> !in_ch.ready)
    else $error("ready while busy");
  // an out-of-range read returns zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.in_range |-> out_ch.cell_value == 8'd0)
    else $error("nonzero value outside canvas");
  // rad_r tracks the accepted radius
  a_rad: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> rad_r == $past(in_ch.radius))
    else $error("radius not captured");

endmodule
